// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the back end of the divisor table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while arst_n is low.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("divisor table assertion failed");

// Condition that must never be seen.
`define ASSERT_NEVER(label, expr) `ASSERT_CLK(label, !(expr))

`endif

// ===== rtl/core/mdt_pkg.sv =====
// Types, constants and compare functions of the monomial divisor table.
`default_nettype none
package mdt_pkg;
	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_VARS      = 8;
	localparam int MAX_MATCHES   = 32;

	localparam int EXP_W    = 16;
	localparam int COMP_W   = 4;
	localparam int ID_W     = 16;
	localparam int LIMIT_W  = 6;
	localparam int VC_W     = 4;
	localparam int NUM_EXPS = 8;
	localparam logic [VC_W-1:0] VC_RESET = 4'd8;

	localparam int IDX_W    = $clog2(TABLE_ENTRIES);
	localparam int CNT_W    = IDX_W + 1;
	localparam int NMATCH_W = $clog2(MAX_MATCHES + 1);

	// input beat layout
	localparam int IN_COMP_LSB  = 0;
	localparam int IN_ID_LSB    = IN_COMP_LSB + COMP_W;
	localparam int IN_LIMIT_LSB = IN_ID_LSB + ID_W;
	localparam int IN_EXP_LSB   = IN_LIMIT_LSB + LIMIT_W;
	localparam int IN_BITS      = IN_EXP_LSB + NUM_EXPS * EXP_W;
	localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int IN_USER_W    = 2;

	// output beat layout
	localparam int OUT_DATA_W  = ID_W;
	localparam int OUT_USER_W  = 3;
	localparam int USER_FOUND  = 0;
	localparam int USER_STATUS = 1;
	localparam int USER_TRUNC  = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIRST  = 2'd1,
		CMD_ALL    = 2'd2,
		CMD_EXACT  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_CACHE,
		B_SCAN,
		B_FLUSH
	} back_state_t;

	typedef logic [MAX_VARS-1:0][EXP_W-1:0] exps_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [COMP_W-1:0]   comp;
		logic [ID_W-1:0]     id;
		logic [NMATCH_W-1:0] lim;
		logic                capped;
		exps_t               exps;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]   value;
		logic [COMP_W-1:0] comp;
		exps_t             exps;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	function automatic logic [MAX_VARS-1:0] var_mask(input logic [VC_W-1:0] vc);
		logic [MAX_VARS-1:0] m;
		for (int v = 0; v < MAX_VARS; v++) begin
			m[v] = (int'(vc) > v);
		end
		return m;
	endfunction

	function automatic logic divides(input exps_t e, input exps_t q,
			input logic [MAX_VARS-1:0] m);
		logic ok;
		ok = 1'b1;
		for (int v = 0; v < MAX_VARS; v++) begin
			if (m[v] && (e[v] > q[v])) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic equals(input exps_t e, input exps_t q,
			input logic [MAX_VARS-1:0] m);
		logic ok;
		ok = 1'b1;
		for (int v = 0; v < MAX_VARS; v++) begin
			if (m[v] && (e[v] != q[v])) ok = 1'b0;
		end
		return ok;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mdt_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module mdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/mdt_front.sv =====
// Front end: takes input beats, decodes them and queues them for the scanner.
`default_nettype none
module mdt_front
	import mdt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [IN_USER_W-1:0] s_tuser,
	output      logic                 q_valid,
	input  wire logic                 q_pop,
	output      item_t                q_item
);
	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	item_t              dec;
	logic [LIMIT_W-1:0] lim_in;
	logic               push, pop;

	always_comb begin
		lim_in     = s_tdata[IN_LIMIT_LSB +: LIMIT_W];
		dec.cmd    = cmd_t'(s_tuser);
		dec.comp   = s_tdata[IN_COMP_LSB +: COMP_W];
		dec.id     = s_tdata[IN_ID_LSB +: ID_W];
		// no limit, or anything above the cap, means the cap
		dec.capped = (lim_in == '0) || (int'(lim_in) > MAX_MATCHES);
		dec.lim    = dec.capped ? NMATCH_W'(MAX_MATCHES) : NMATCH_W'(lim_in);
		for (int v = 0; v < MAX_VARS; v++) begin
			dec.exps[v] = s_tdata[IN_EXP_LSB + v * EXP_W +: EXP_W];
		end
	end

	assign s_tready = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign q_item   = slot_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/mdt_back.sv =====
// Back end: insert, cache probe and table scan, with the output register.
`default_nettype none
`include "assert_macros.svh"
module mdt_back
	import mdt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VC_W-1:0]       var_count,
	input  wire logic                  q_valid,
	output      logic                  q_pop,
	input  wire item_t                 q_item,
	output      logic                  ram_we,
	output      logic [IDX_W-1:0]      ram_addr,
	output      logic [ROW_W-1:0]      ram_wdata,
	input  wire logic [ROW_W-1:0]      ram_rdata,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [OUT_DATA_W-1:0] m_tdata,
	output      logic [OUT_USER_W-1:0] m_tuser,
	output      logic                  m_tlast
);
	back_state_t         state_q, state_d;
	item_t               cur_q, cur_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    cache_idx_q, cache_idx_d;
	logic [COMP_W-1:0]   cache_comp_q, cache_comp_d;
	logic                cache_vld_q, cache_vld_d;
	logic [CNT_W-1:0]    issue_q, issue_d;
	logic                cmp_vld_s1, cmp_vld_d;
	logic [IDX_W-1:0]    cmp_idx_s1, cmp_idx_d;
	logic [NMATCH_W-1:0] nmatch_q, nmatch_d;
	logic                hold_vld_q, hold_vld_d;
	logic [ID_W-1:0]     hold_id_q, hold_id_d;
	logic                trunc_q, trunc_d;

	logic                out_vld_q, out_found_q, out_status_q, out_trunc_q, out_last_q;
	logic [ID_W-1:0]     out_id_q;
	logic                emit, e_found, e_status, e_trunc, e_last;
	logic [ID_W-1:0]     e_id;

	row_t                row, wrow;
	logic [MAX_VARS-1:0] mask;
	logic                div_ok, eq_ok, hit, match, stall, out_free, cache_try;

	assign out_free = !out_vld_q || m_tready;
	assign row      = row_t'(ram_rdata);
	assign mask     = var_mask(var_count);
	assign div_ok   = divides(row.exps, cur_q.exps, mask);
	assign eq_ok    = equals(row.exps, cur_q.exps, mask);
	assign hit      = (row.comp == cur_q.comp) && ((cur_q.cmd == CMD_EXACT) ? eq_ok : div_ok);
	assign match    = cmp_vld_s1 && hit;
	assign stall    = match && ((cur_q.cmd == CMD_ALL) ? hold_vld_q : 1'b1) && !out_free;
	assign cache_try = cache_vld_q && (cache_comp_q == cur_q.comp)
		&& (CNT_W'(cache_idx_q) < count_q)
		&& ((cur_q.cmd == CMD_FIRST)
			|| ((cur_q.cmd == CMD_ALL) && (cur_q.lim == NMATCH_W'(1))));

	always_comb begin
		wrow.value = cur_q.id;
		wrow.comp  = cur_q.comp;
		wrow.exps  = cur_q.exps;
	end

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		count_d      = count_q;
		cache_idx_d  = cache_idx_q;
		cache_comp_d = cache_comp_q;
		cache_vld_d  = cache_vld_q;
		issue_d      = issue_q;
		cmp_vld_d    = cmp_vld_s1;
		cmp_idx_d    = cmp_idx_s1;
		nmatch_d     = nmatch_q;
		hold_vld_d   = hold_vld_q;
		hold_id_d    = hold_id_q;
		trunc_d      = trunc_q;
		q_pop        = 1'b0;
		ram_we       = 1'b0;
		ram_addr     = issue_q[IDX_W-1:0];
		ram_wdata    = ROW_W'(wrow);
		emit         = 1'b0;
		e_found      = 1'b0;
		e_id         = '0;
		e_status     = 1'b0;
		e_trunc      = 1'b0;
		e_last       = 1'b1;

		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cur_d   = q_item;
					state_d = B_START;
				end
			end
			B_START: begin
				issue_d    = '0;
				cmp_vld_d  = 1'b0;
				nmatch_d   = '0;
				hold_vld_d = 1'b0;
				trunc_d    = 1'b0;
				if (cur_q.cmd == CMD_INSERT) begin
					if (out_free) begin
						emit     = 1'b1;
						e_status = (count_q == CNT_W'(TABLE_ENTRIES));
						if (count_q != CNT_W'(TABLE_ENTRIES)) begin
							ram_we   = 1'b1;
							ram_addr = count_q[IDX_W-1:0];
							count_d  = count_q + 1'b1;
						end
						state_d = B_IDLE;
					end
				end else if (cache_try) begin
					ram_addr = cache_idx_q;
					state_d  = B_CACHE;
				end else begin
					state_d = B_SCAN;
				end
			end
			B_CACHE: begin
				// address held so the read data stays put while the output waits
				ram_addr = cache_idx_q;
				if (div_ok) begin
					if (out_free) begin
						emit    = 1'b1;
						e_found = 1'b1;
						e_id    = row.value;
						state_d = B_IDLE;
					end
				end else begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (stall) begin
					// replay the entry under compare
					ram_addr = cmp_idx_s1;
				end else begin
					if (match && (cur_q.cmd != CMD_EXACT)) begin
						cache_idx_d  = cmp_idx_s1;
						cache_comp_d = cur_q.comp;
						cache_vld_d  = 1'b1;
					end
					if (match && (cur_q.cmd != CMD_ALL)) begin
						emit      = 1'b1;
						e_found   = 1'b1;
						e_id      = row.value;
						cmp_vld_d = 1'b0;
						state_d   = B_IDLE;
					end else if (match && ((nmatch_q + 1'b1) >= cur_q.lim)) begin
						emit       = hold_vld_q;
						e_found    = 1'b1;
						e_id       = hold_id_q;
						e_last     = 1'b0;
						hold_vld_d = 1'b1;
						hold_id_d  = row.value;
						nmatch_d   = nmatch_q + 1'b1;
						trunc_d    = cur_q.capped;
						cmp_vld_d  = 1'b0;
						state_d    = B_FLUSH;
					end else begin
						if (match) begin
							// previous match goes out, this one is held back
							emit       = hold_vld_q;
							e_found    = 1'b1;
							e_id       = hold_id_q;
							e_last     = 1'b0;
							hold_vld_d = 1'b1;
							hold_id_d  = row.value;
							nmatch_d   = nmatch_q + 1'b1;
						end
						if (issue_q < count_q) begin
							ram_addr  = issue_q[IDX_W-1:0];
							cmp_vld_d = 1'b1;
							cmp_idx_d = issue_q[IDX_W-1:0];
							issue_d   = issue_q + 1'b1;
						end else begin
							cmp_vld_d = 1'b0;
							if (!cmp_vld_s1) begin
								if (hold_vld_q) begin
									state_d = B_FLUSH;
								end else if (out_free) begin
									emit    = 1'b1;
									state_d = B_IDLE;
								end
							end
						end
					end
				end
			end
			B_FLUSH: begin
				if (out_free) begin
					emit       = 1'b1;
					e_found    = 1'b1;
					e_id       = hold_id_q;
					e_trunc    = trunc_q;
					hold_vld_d = 1'b0;
					state_d    = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			count_q      <= '0;
			cache_idx_q  <= '0;
			cache_comp_q <= '0;
			cache_vld_q  <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			hold_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			cache_idx_q  <= cache_idx_d;
			cache_comp_q <= cache_comp_d;
			cache_vld_q  <= cache_vld_d;
			cmp_vld_s1   <= cmp_vld_d;
			hold_vld_q   <= hold_vld_d;
			if (emit) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		issue_q    <= issue_d;
		cmp_idx_s1 <= cmp_idx_d;
		nmatch_q   <= nmatch_d;
		hold_id_q  <= hold_id_d;
		trunc_q    <= trunc_d;
		if (emit) begin
			out_found_q  <= e_found;
			out_id_q     <= e_id;
			out_status_q <= e_status;
			out_trunc_q  <= e_trunc;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_id_q;
	assign m_tlast  = out_last_q;
	always_comb begin
		m_tuser              = '0;
		m_tuser[USER_FOUND]  = out_found_q;
		m_tuser[USER_STATUS] = out_status_q;
		m_tuser[USER_TRUNC]  = out_trunc_q;
	end

	`ASSERT_CLK(a_insert_grows, ram_we |=> (count_q == $past(count_q) + 1'b1))
	`ASSERT_CLK(a_cache_in_table, cache_vld_q |-> (CNT_W'(cache_idx_q) < count_q))
	`ASSERT_CLK(a_refused_alone, (out_vld_q && out_status_q) |-> (!out_found_q && out_last_q))
	`ASSERT_NEVER(a_hold_only_all, hold_vld_q && (cur_q.cmd != CMD_ALL))
endmodule
`default_nettype wire

// ===== rtl/core/monomial_divisor_table_top.sv =====
// Top level of the monomial divisor table: config register, front, back and entry RAM.
// Usage:
//  - s_* channel: one command per beat. s_tuser = cmd (0 insert, 1 find first,
//    2 find all, 3 find exact). s_tdata, from bit 0 up: comp, entry_id,
//    match_limit, exp_0 .. exp_7, zero padding to 160 bits.
//  - m_* channel: result beats. m_tdata = match_id; m_tuser from bit 0 up:
//    found, status, truncated; m_tlast marks the final beat of a command.
//  - cfg_* channel: writes var_count (always ready); write it only while idle.
//  - A scan reads the entry RAM one entry per cycle unless a match waits
//    on m_tready. Find all gives one beat per match, a beat of one match
//    being held back until the next match or the end of the scan.
//  - A two-deep command queue lets up to two commands wait while the back
//    end works; commands run strictly one at a time, in order.
//  - Reset empties the table and the cache and sets var_count to 8; there
//    is no clearing pass, entries are only read below the fill count.
//  - When a result beat has to wait on m_tready, the scan holds on the pending
//    match and replays its RAM read, so no result is lost or repeated.
`default_nettype none
module monomial_divisor_table_top
	import mdt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // comp, entry_id, match_limit, exp_0..exp_7
	input  wire logic [IN_USER_W-1:0]  s_tuser,   // cmd
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [OUT_DATA_W-1:0] m_tdata,   // match_id
	output      logic [OUT_USER_W-1:0] m_tuser,   // found, status, truncated
	output      logic                  m_tlast,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [VC_W-1:0]       cfg_data   // var_count
);
	logic [VC_W-1:0]  var_count_q;
	logic             q_valid, q_pop;
	item_t            q_item;
	logic             ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= VC_RESET;
		end else if (cfg_valid) begin
			var_count_q <= cfg_data;
		end
	end

	mdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	mdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.var_count (var_count_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// one row per entry: id, component tag, all exponents
	mdt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TABLE_ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);
endmodule
`default_nettype wire

// ===== test/monomial_divisor_table_top_tb.sv =====
// Self-checking testbench for the monomial divisor table top level.
`timescale 1ns / 100ps
`default_nettype none
module monomial_divisor_table_top_tb;
	localparam int N_ENT = mdt_pkg::TABLE_ENTRIES;
	localparam int N_VAR = mdt_pkg::MAX_VARS;
	localparam int N_CAP = mdt_pkg::MAX_MATCHES;

	typedef mdt_pkg::cmd_t cmd_t;

	// one command as the sender sees it
	typedef struct packed {
		cmd_t               cmd;
		logic [3:0]         comp;
		logic [15:0]        id;
		logic [5:0]         lim;
		logic [7:0][15:0]   e;
	} cmd_rec_t;

	// one result beat
	typedef struct packed {
		logic        found;
		logic [15:0] id;
		logic        status;
		logic        trunc;
		logic        last;
	} beat_t;

	// one row of the directed table
	typedef struct {
		cmd_rec_t r;
		bit       typed;
		beat_t    want;
	} step_t;

	localparam beat_t NONE_FOUND = '{1'b0, 16'h0, 1'b0, 1'b0, 1'b1};
	localparam beat_t INS_OK     = '{1'b0, 16'h0, 1'b0, 1'b0, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mdt_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [mdt_pkg::IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mdt_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [mdt_pkg::OUT_USER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mdt_pkg::VC_W-1:0] cfg_data = '0;

	monomial_divisor_table_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// shadow of the table, the match cache and var_count
	logic [7:0][15:0] tbl_exp[N_ENT];
	logic [3:0]       tbl_comp[N_ENT];
	logic [15:0]      tbl_val[N_ENT];
	int               tbl_fill = 0;
	int               hit_idx = 0;
	logic [3:0]       hit_comp = '0;
	bit               hit_ok = 0;
	logic [3:0]       var_cnt = mdt_pkg::VC_RESET;

	beat_t pending_beats[$];
	beat_t fresh[$];
	beat_t head;
	int    fails = 0;
	int    beats_seen = 0;
	int    cmds_sent = 0;
	int    settings_run = 1;
	bit    quiet = 0;

	function automatic bit divides_q(int ent, logic [7:0][15:0] q);
		int n;
		n = (var_cnt > N_VAR) ? N_VAR : var_cnt;
		for (int v = 0; v < n; v++)
			if (tbl_exp[ent][v] > q[v]) return 0;
		return 1;
	endfunction

	function automatic bit equals_q(int ent, logic [7:0][15:0] q);
		int n;
		n = (var_cnt > N_VAR) ? N_VAR : var_cnt;
		for (int v = 0; v < n; v++)
			if (tbl_exp[ent][v] != q[v]) return 0;
		return 1;
	endfunction

	function automatic bit cache_ok(logic [3:0] comp, logic [7:0][15:0] q);
		return hit_ok && hit_comp == comp && hit_idx < tbl_fill && divides_q(hit_idx, q);
	endfunction

	// expected beats of one command into fresh[], updating the shadow state
	task automatic predict_cmd(input cmd_rec_t r);
		int  lim;
		int  n;
		bit  capped;
		bit  done;
		fresh.delete();
		done = 0;
		case (r.cmd)
			mdt_pkg::CMD_INSERT: begin
				if (tbl_fill >= N_ENT) begin
					fresh.insert(fresh.size(), '{1'b0, 16'h0, 1'b1, 1'b0, 1'b1});
				end else begin
					tbl_exp[tbl_fill] = r.e;
					tbl_comp[tbl_fill] = r.comp;
					tbl_val[tbl_fill] = r.id;
					tbl_fill++;
					fresh.insert(fresh.size(), INS_OK);
				end
			end
			mdt_pkg::CMD_FIRST: begin
				if (cache_ok(r.comp, r.e)) begin
					fresh.insert(fresh.size(), '{1'b1, tbl_val[hit_idx], 1'b0, 1'b0, 1'b1});
				end else begin
					for (int k = 0; k < tbl_fill && !done; k++)
						if (tbl_comp[k] == r.comp && divides_q(k, r.e)) begin
							hit_idx = k; hit_comp = r.comp; hit_ok = 1;
							fresh.insert(fresh.size(), '{1'b1, tbl_val[k], 1'b0, 1'b0, 1'b1});
							done = 1;
						end
					if (!done) fresh.insert(fresh.size(), NONE_FOUND);
				end
			end
			mdt_pkg::CMD_ALL: begin
				// a limit of zero or above the cap means "up to the cap"
				capped = (r.lim == 0 || r.lim > N_CAP);
				lim = capped ? N_CAP : r.lim;
				n = 0;
				if (lim == 1 && cache_ok(r.comp, r.e)) begin
					fresh.insert(fresh.size(), '{1'b1, tbl_val[hit_idx], 1'b0, 1'b0, 1'b1});
				end else begin
					for (int k = 0; k < tbl_fill && n < lim; k++)
						if (tbl_comp[k] == r.comp && divides_q(k, r.e)) begin
							hit_idx = k; hit_comp = r.comp; hit_ok = 1;
							fresh.insert(fresh.size(), '{1'b1, tbl_val[k], 1'b0, 1'b0, 1'b0});
							n++;
						end
					if (n == 0) begin
						fresh.insert(fresh.size(), NONE_FOUND);
					end else begin
						fresh[n-1].trunc = (n >= lim) && capped;
						fresh[n-1].last = 1'b1;
					end
				end
			end
			default: begin
				for (int k = 0; k < tbl_fill && !done; k++)
					if (tbl_comp[k] == r.comp && equals_q(k, r.e)) begin
						fresh.insert(fresh.size(), '{1'b1, tbl_val[k], 1'b0, 1'b0, 1'b1});
						done = 1;
					end
				if (!done) fresh.insert(fresh.size(), NONE_FOUND);
			end
		endcase
	endtask

	// drive one command beat, sometimes with a random gap ahead of it
	task automatic send_cmd(input cmd_rec_t r, input bit typed, input beat_t want);
		if (!quiet && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= mdt_pkg::IN_DATA_W'({r.e, r.lim, r.id, r.comp});
		do @(posedge clk); while (!s_tready);
		predict_cmd(r);
		if (typed) pending_beats.insert(pending_beats.size(), want);
		else foreach (fresh[k]) pending_beats.insert(pending_beats.size(), fresh[k]);
		cmds_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
	endtask

	// var_count write, only with the block idle
	task automatic write_var_count(input logic [3:0] vc);
		drain_results();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= vc;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		var_cnt = vc;
	endtask

	function automatic cmd_rec_t mk(cmd_t c, logic [3:0] comp, logic [15:0] id,
			logic [5:0] lim, logic [15:0] ev);
		cmd_rec_t r;
		r.cmd = c; r.comp = comp; r.id = id; r.lim = lim;
		for (int v = 0; v < N_VAR; v++) r.e[v] = ev;
		return r;
	endfunction

	// random command, mostly small exponents and a few components so that
	// divisors actually turn up; sometimes a query reuses a stored vector
	function automatic cmd_rec_t rand_cmd();
		cmd_rec_t r;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		r.cmd = pick < 35 ? mdt_pkg::CMD_INSERT : pick < 60 ? mdt_pkg::CMD_FIRST :
			pick < 80 ? mdt_pkg::CMD_ALL : mdt_pkg::CMD_EXACT;
		r.comp = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
		r.id = 16'($urandom_range(0, 65535));
		r.lim = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
		for (int v = 0; v < N_VAR; v++) begin
			pick = $urandom_range(0, 9);
			r.e[v] = pick < 7 ? 16'($urandom_range(0, 3)) :
				pick < 9 ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
		end
		if (r.cmd != mdt_pkg::CMD_INSERT && tbl_fill != 0 && $urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, tbl_fill - 1);
			r.comp = tbl_comp[k];
			r.e = tbl_exp[k];
		end
		return r;
	endfunction

	// result side: random back-pressure and field checks against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected: match_id %h", m_tdata);
				fails++;
			end else begin
				head = pending_beats.pop_front();
				if (m_tuser[mdt_pkg::USER_FOUND] !== head.found) begin
					$error("found: expected %0d, got %0d", head.found, m_tuser[mdt_pkg::USER_FOUND]);
					fails++;
				end
				if (m_tdata !== head.id) begin
					$error("match_id: expected %h, got %h", head.id, m_tdata);
					fails++;
				end
				if (m_tuser[mdt_pkg::USER_STATUS] !== head.status) begin
					$error("status: expected %0d, got %0d", head.status, m_tuser[mdt_pkg::USER_STATUS]);
					fails++;
				end
				if (m_tuser[mdt_pkg::USER_TRUNC] !== head.trunc) begin
					$error("truncated: expected %0d, got %0d", head.trunc, m_tuser[mdt_pkg::USER_TRUNC]);
					fails++;
				end
				if (m_tlast !== head.last) begin
					$error("last: expected %0d, got %0d", head.last, m_tlast);
					fails++;
				end
			end
		end
		m_tready <= quiet || ($urandom_range(0, 99) >= 33);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		step_t dir[$];
		step_t st;
		cmd_rec_t r;
		logic [3:0] vc_plan[6];

		vc_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, the cache paths, limits around the cap
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_FIRST, 1, 0, 0, 5), 1, NONE_FOUND});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 0, 5), 1, NONE_FOUND});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_EXACT, 1, 0, 0, 5), 1, NONE_FOUND});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_INSERT, 0, 16'h0000, 0, 16'h0000), 1, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_INSERT, 15, 16'hFFFF, 63, 16'hFFFF), 1, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_INSERT, 1, 16'h1111, 0, 3), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_INSERT, 1, 16'h2222, 0, 1), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_INSERT, 1, 16'h3333, 0, 2), 0, INS_OK});
		r = mk(mdt_pkg::CMD_INSERT, 1, 16'h4444, 0, 0);
		r.e[7] = 16'd9;
		dir.insert(dir.size(), '{r, 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_FIRST, 1, 0, 0, 2), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_FIRST, 1, 0, 0, 3), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 0, 3), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 1, 3), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 2, 3), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 32, 16'hFFFF), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 1, 0, 63, 16'hFFFF), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_EXACT, 15, 0, 0, 16'hFFFF), 1,
			'{1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1}});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_EXACT, 0, 0, 0, 16'h0000), 1,
			'{1'b1, 16'h0000, 1'b0, 1'b0, 1'b1}});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_ALL, 0, 0, 0, 16'hFFFF), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_FIRST, 15, 0, 0, 16'hFFFE), 0, INS_OK});
		dir.insert(dir.size(), '{mk(mdt_pkg::CMD_EXACT, 1, 0, 0, 2), 0, INS_OK});
		foreach (dir[k]) begin
			st = dir[k];
			send_cmd(st.r, st.typed, st.want);
		end

		// random phases, one per var_count setting, extremes included
		foreach (vc_plan[p]) begin
			write_var_count(vc_plan[p]);
			settings_run++;
			quiet = (p == 2);
			for (int k = 0; k < 12; k++) begin
				// one hold-off until every result is home
				if (p == 1 && k == 6) drain_results();
				send_cmd(rand_cmd(), 0, INS_OK);
			end
		end
		quiet = 0;

		// fill the table: many equal divisors in one component, then refusals
		write_var_count(4'd8);
		while (tbl_fill < N_ENT + 3) begin
			r = rand_cmd();
			r.cmd = mdt_pkg::CMD_INSERT;
			r.comp = 4'd2;
			r.e = '0;
			send_cmd(r, 0, INS_OK);
			if (tbl_fill == N_ENT) break;
		end
		for (int k = 0; k < 3; k++)
			send_cmd(mk(mdt_pkg::CMD_INSERT, 2, 16'hABCD, 0, 0), 1,
				'{1'b0, 16'h0, 1'b1, 1'b0, 1'b1});
		send_cmd(mk(mdt_pkg::CMD_ALL, 2, 0, 0, 16'h0007), 0, INS_OK);
		send_cmd(mk(mdt_pkg::CMD_ALL, 2, 0, 40, 16'h0007), 0, INS_OK);
		send_cmd(mk(mdt_pkg::CMD_ALL, 2, 0, 32, 16'h0007), 0, INS_OK);
		send_cmd(mk(mdt_pkg::CMD_FIRST, 2, 0, 0, 16'h0001), 0, INS_OK);
		send_cmd(mk(mdt_pkg::CMD_EXACT, 15, 0, 0, 16'hFFFF), 0, INS_OK);
		for (int k = 0; k < 12; k++) send_cmd(rand_cmd(), 0, INS_OK);

		drain_results();
		repeat (300) @(posedge clk);

		$display("Ran %0d commands over %0d var_count settings; %0d result beats checked.",
			cmds_sent, settings_run, beats_seen);
		$display("Table filled to capacity, with refused inserts and capped find-all runs.");
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
